// ----- src/sksb_pkg.sv -----
package sksb_pkg;

    // Default table geometry
    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int KEY_BYTES_MAX_DEF = 8;

    // Field widths
    localparam int ENTRY_COUNT_W = 13;
    localparam int KEY_BITS_W    = 7;
    localparam int INDEX_W       = 12;
    localparam int KEY_W         = 64;
    localparam int TEXT_W        = 32;
    localparam int SPAN_W        = 2 * TEXT_W;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // Register reset values
    localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = '0;
    localparam logic [KEY_BITS_W-1:0]    KEY_BITS_RESET    = 7'd23;

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Register indexes, taken from address bit 2
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_KEY_BITS    = 1'b1;

    // Configuration handed to the search sequencer
    typedef struct packed {
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic [KEY_BITS_W-1:0]    key_bits;
    } t_cfg;

endpackage

// ----- src/sksb_table.sv -----
module sksb_table #(
    parameter int DEPTH = sksb_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [sksb_pkg::KEY_W-1:0]  i_wr_key,
    input  logic [sksb_pkg::SPAN_W-1:0] i_wr_span,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [sksb_pkg::KEY_W-1:0]  o_rd_key,
    output logic [sksb_pkg::SPAN_W-1:0] o_rd_span
);

    logic [sksb_pkg::KEY_W-1:0]  r_keys  [DEPTH];
    logic [sksb_pkg::SPAN_W-1:0] r_spans [DEPTH];

    // Write port: one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_keys[i_wr_addr]  <= i_wr_key;
            r_spans[i_wr_addr] <= i_wr_span;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key  <= r_keys[i_rd_addr];
            o_rd_span <= r_spans[i_rd_addr];
        end
    end

endmodule

// ----- src/sksb_search.sv -----
module sksb_search #(
    parameter int TABLE_DEPTH   = sksb_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES_MAX = sksb_pkg::KEY_BYTES_MAX_DEF,
    parameter int AW            = $clog2(TABLE_DEPTH)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sksb_pkg::t_cfg                       i_cfg,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic                                 i_op,
    input  logic [sksb_pkg::INDEX_W-1:0]         i_entry_index,
    input  logic [sksb_pkg::KEY_W-1:0]           i_search_key,
    input  logic [sksb_pkg::TEXT_W-1:0]          i_text_first,
    input  logic [sksb_pkg::TEXT_W-1:0]          i_text_last,
    output logic                                 o_wr_en,
    output logic [AW-1:0]                        o_wr_addr,
    output logic [sksb_pkg::KEY_W-1:0]           o_wr_key,
    output logic [sksb_pkg::SPAN_W-1:0]          o_wr_span,
    output logic                                 o_rd_en,
    output logic [AW-1:0]                        o_rd_addr,
    input  logic [sksb_pkg::KEY_W-1:0]           i_rd_key,
    input  logic [sksb_pkg::SPAN_W-1:0]          i_rd_span,
    output logic                                 o_result_valid,
    output logic                                 o_found,
    output logic [sksb_pkg::TEXT_W-1:0]          o_match_first,
    output logic [sksb_pkg::TEXT_W-1:0]          o_match_last
);

    // Compare width wide enough for the count register and for the depth itself.
    localparam int CMPW = (AW + 1 > sksb_pkg::ENTRY_COUNT_W) ? AW + 1 : sksb_pkg::ENTRY_COUNT_W;
    localparam int NBW  = sksb_pkg::KEY_BITS_W + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_PROBE, ST_COMPARE} t_state;

    t_state r_state, n_state;
    logic   n_result_valid, n_found;
    logic [sksb_pkg::TEXT_W-1:0] n_match_first, n_match_last;

    logic [AW:0]                 r_lo, n_lo;
    logic [AW:0]                 r_hx, n_hx;
    logic [AW:0]                 r_mid, n_mid;
    logic [sksb_pkg::KEY_W-1:0]  r_want, n_want;
    logic [sksb_pkg::KEY_W-1:0]  r_mask, n_mask;

    logic                        accept;
    logic [NBW-1:0]              nbytes_raw, nbytes;
    logic [sksb_pkg::KEY_W-1:0]  mask_c;
    logic [CMPW-1:0]             count_ext, count_c, index_ext;
    logic [AW:0]                 mid_c;
    logic [sksb_pkg::KEY_W-1:0]  have;

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && (r_state == ST_IDLE);

    // Number of compared bytes, limited to the widest key supported.
    assign nbytes_raw = (NBW'(i_cfg.key_bits) + NBW'(7)) >> 3;
    assign nbytes     = (nbytes_raw > NBW'(KEY_BYTES_MAX)) ? NBW'(KEY_BYTES_MAX) : nbytes_raw;

    // Byte mask over the low bytes that take part in the compare.
    always_comb begin
        for (int i = 0; i < sksb_pkg::KEY_W / 8; i++) begin
            mask_c[i*8 +: 8] = (nbytes > NBW'(i)) ? 8'hFF : 8'h00;
        end
    end

    // Entry count limited to the table depth.
    assign count_ext = CMPW'(i_cfg.entry_count);
    assign count_c   = (count_ext > CMPW'(TABLE_DEPTH)) ? CMPW'(TABLE_DEPTH) : count_ext;
    assign index_ext = CMPW'(i_entry_index);

    // Probe position between the lower bound and the exclusive upper bound.
    assign mid_c = r_lo + ((r_hx - r_lo - (AW+1)'(1)) >> 1);
    assign have  = i_rd_key & r_mask;

    // Load writes go straight to the table.
    assign o_wr_en   = accept && (i_op == sksb_pkg::OP_LOAD) && (index_ext < CMPW'(TABLE_DEPTH));
    assign o_wr_addr = index_ext[AW-1:0];
    assign o_wr_key  = i_search_key;
    assign o_wr_span = {i_text_first, i_text_last};
    assign o_rd_addr = mid_c[AW-1:0];

    // Sequencer: probe issues a read, compare narrows the bounds.
    always_comb begin
        n_state        = r_state;
        n_result_valid = 1'b0;
        n_found        = o_found;
        n_match_first  = o_match_first;
        n_match_last   = o_match_last;
        n_lo           = r_lo;
        n_hx           = r_hx;
        n_mid          = r_mid;
        n_want         = r_want;
        n_mask         = r_mask;
        o_rd_en        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_op == sksb_pkg::OP_LOOKUP)) begin
                    n_want  = i_search_key & mask_c;
                    n_mask  = mask_c;
                    n_lo    = '0;
                    n_hx    = (nbytes == '0) ? '0 : count_c[AW:0];
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hx) begin
                    o_rd_en = 1'b1;
                    n_mid   = mid_c;
                    n_state = ST_COMPARE;
                end else begin
                    n_result_valid = 1'b1;
                    n_found        = 1'b0;
                    n_match_first  = '0;
                    n_match_last   = '0;
                    n_state        = ST_IDLE;
                end
            end
            ST_COMPARE: begin
                if (have == r_want) begin
                    n_result_valid = 1'b1;
                    n_found        = 1'b1;
                    n_match_first  = i_rd_span[sksb_pkg::SPAN_W-1:sksb_pkg::TEXT_W];
                    n_match_last   = i_rd_span[sksb_pkg::TEXT_W-1:0];
                    n_state        = ST_IDLE;
                end else begin
                    if (r_want < have) begin
                        n_hx = r_mid;
                    end else begin
                        n_lo = r_mid + (AW+1)'(1);
                    end
                    n_state = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            o_result_valid <= n_result_valid;
            o_found        <= n_found;
            o_match_first  <= n_match_first;
            o_match_last   <= n_match_last;
        end
    end

    // Search bounds and the masked key.
    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hx   <= n_hx;
        r_mid  <= n_mid;
        r_want <= n_want;
        r_mask <= n_mask;
    end

endmodule

// ----- src/sorted_key_binary_search_unit.sv -----
// Sorted key table with binary search lookup.
//
// Items enter on start while busy is low. A load item (i_op low) writes the
// key and the two text indices at i_entry_index and produces no
// result; busy stays low. A lookup item (i_op high) raises busy and runs a
// binary search over the first entry_count entries, comparing the low
// ceil(key_bits/8) key bytes (at most KEY_BYTES_MAX) as one unsigned number.
// Each probe issues the table read in the probe state, then compares the
// registered read data in the compare state. Start is not taken again
// until the lookup has delivered its result.
// The result is shown for one cycle with o_result_valid high; the receiver
// cannot stall it. On a miss o_found and both match fields are zero.
// Reset clears the sequencer, entry_count to 0 and key_bits to 23; table
// contents are undefined until loaded. Registers are written through the
// APB port (entry_count at 0x0, key_bits at 0x4); the user must write them
// only while the block is idle, as the block itself does not enforce this.
module sorted_key_binary_search_unit #(
    parameter int TABLE_DEPTH   = sksb_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES_MAX = sksb_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sksb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sksb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sksb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic [sksb_pkg::INDEX_W-1:0]        i_entry_index,
    input  logic [sksb_pkg::KEY_W-1:0]          i_search_key,
    input  logic [sksb_pkg::TEXT_W-1:0]         i_text_first,
    input  logic [sksb_pkg::TEXT_W-1:0]         i_text_last,
    output logic                                o_result_valid,
    output logic                                o_found,
    output logic [sksb_pkg::TEXT_W-1:0]         o_match_first,
    output logic [sksb_pkg::TEXT_W-1:0]         o_match_last
);

    localparam int AW = $clog2(TABLE_DEPTH);

    sksb_pkg::t_cfg r_cfg;
    logic           cfg_write;

    logic                          wr_en, rd_en;
    logic [AW-1:0]                 wr_addr, rd_addr;
    logic [sksb_pkg::KEY_W-1:0]    wr_key, rd_key;
    logic [sksb_pkg::SPAN_W-1:0]   wr_span, rd_span;

    // Configuration registers behind the APB port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_count <= sksb_pkg::ENTRY_COUNT_RESET;
            r_cfg.key_bits    <= sksb_pkg::KEY_BITS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                sksb_pkg::REG_ENTRY_COUNT: r_cfg.entry_count <= pwdata[sksb_pkg::ENTRY_COUNT_W-1:0];
                sksb_pkg::REG_KEY_BITS:    r_cfg.key_bits    <= pwdata[sksb_pkg::KEY_BITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[2])
            sksb_pkg::REG_ENTRY_COUNT: prdata = sksb_pkg::APB_DATA_W'(r_cfg.entry_count);
            sksb_pkg::REG_KEY_BITS:    prdata = sksb_pkg::APB_DATA_W'(r_cfg.key_bits);
            default:                   prdata = '0;
        endcase
    end

    sksb_search #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .KEY_BYTES_MAX (KEY_BYTES_MAX),
        .AW            (AW)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_start        (start),
        .o_busy         (busy),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_search_key   (i_search_key),
        .i_text_first   (i_text_first),
        .i_text_last    (i_text_last),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_key       (wr_key),
        .o_wr_span      (wr_span),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_key       (rd_key),
        .i_rd_span      (rd_span),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_match_first  (o_match_first),
        .o_match_last   (o_match_last)
    );

    sksb_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_span (wr_span),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_span (rd_span)
    );

endmodule

// ----- src/sksb_checker.sv -----
module sksb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_op,
    input logic                        o_result_valid,
    input logic                        o_found,
    input logic [sksb_pkg::TEXT_W-1:0] o_match_first,
    input logic [sksb_pkg::TEXT_W-1:0] o_match_last
);

    // A lookup transfer makes the block busy in the following cycle.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == sksb_pkg::OP_LOOKUP)) |=> busy)
        else $error("lookup transfer did not raise busy");

    // A load transfer leaves the block idle and gives no result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == sksb_pkg::OP_LOAD)) |=> (!busy && !o_result_valid))
        else $error("load transfer disturbed the sequencer");

    // Results are single-cycle strobes that follow a busy period.
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a preceding lookup");

    // A miss carries zero text indices.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> ((o_match_first == '0) && (o_match_last == '0)))
        else $error("miss result carries non-zero indices");

endmodule

bind sorted_key_binary_search_unit sksb_checker u_sksb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_op           (i_op),
    .o_result_valid (o_result_valid),
    .o_found        (o_found),
    .o_match_first  (o_match_first),
    .o_match_last   (o_match_last)
);
